// File: rtl/lscbe_pkg.sv
// Shared constants and operation codes for the load/store/compare/branch execute block.
package lscbe_pkg;

    localparam int MEMORY_BYTES   = 65536;
    localparam int REGISTER_COUNT = 8;

    localparam int MEM_AW      = $clog2(MEMORY_BYTES);
    localparam int BANK_DEPTH  = MEMORY_BYTES / 2;
    localparam int BANK_AW     = MEM_AW - 1;
    localparam int RF_AW       = $clog2(REGISTER_COUNT);

    localparam int LAT_W = 10;
    localparam logic [LAT_W-1:0] LATENCY_RESET = 10'd300;

    localparam int PADDR_W = 2;

    typedef enum logic [3:0] {
        OP_LBZ  = 4'd0,
        OP_LHZ  = 4'd1,
        OP_STB  = 4'd2,
        OP_STH  = 4'd3,
        OP_CMPI = 4'd4,
        OP_ADDI = 4'd5,
        OP_BEQ  = 4'd6,
        OP_B    = 4'd7,
        OP_CLR  = 4'd8
    } op_t;

    typedef struct packed {
        logic lt;
        logic gt;
        logic eq;
    } flags_t;

endpackage

// File: rtl/load_store_compare_branch_execute.sv
// Execute stage: register file, banked byte memory, compare flags and counters.
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | operation, target_reg, base_reg, immediate,
//           |           |                     | current_address
//   m_      | out       | m_valid / m_ready   | branch_taken, branch_target, flags, counts
//   apb     | in        | psel/penable/pready | memory_latency, paddr not decoded
//
// One word per cycle sustained while the output is not stalled; an accepted word goes into the
// execute stage (register file read at acceptance), then execute and memory access into the output register.
// After reset a clearing pass writes zero to memory and the register file, one row of both
// byte banks per cycle over all MEMORY_BYTES/2 rows; s_ready stays low until it is done.
// Load data returns through a writeback stage and is forwarded to the next word.
// A stalled output register holds the execute stage; the writeback stage always drains.
module load_store_compare_branch_execute (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_operation,
    input  logic [2:0]            s_target_reg,
    input  logic [2:0]            s_base_reg,
    input  logic signed [15:0]    s_immediate,
    input  logic [31:0]           s_current_address,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_branch_taken,
    output logic [31:0]           m_branch_target,
    output logic                  m_flag_lt,
    output logic                  m_flag_gt,
    output logic                  m_flag_eq,
    output logic [63:0]           m_instruction_count,
    output logic [63:0]           m_cycle_count,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [lscbe_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int MEM_AW  = lscbe_pkg::MEM_AW;
    localparam int BANK_AW = lscbe_pkg::BANK_AW;
    localparam int RF_AW   = lscbe_pkg::RF_AW;
    localparam int LAT_W   = lscbe_pkg::LAT_W;

    // storage
    logic [31:0] rf_mem   [lscbe_pkg::REGISTER_COUNT];
    logic [7:0]  mem_even [lscbe_pkg::BANK_DEPTH];
    logic [7:0]  mem_odd  [lscbe_pkg::BANK_DEPTH];

    // configuration
    logic [LAT_W-1:0] latency_reg;

    // clearing pass
    logic               clearing_reg;
    logic [BANK_AW-1:0] clr_cnt_reg;

    // execute stage
    logic               s1_valid_reg;
    logic [3:0]         s1_op_reg;
    logic [RF_AW-1:0]   s1_rt_reg;
    logic [RF_AW-1:0]   s1_ra_reg;
    logic signed [15:0] s1_imm_reg;
    logic [31:0]        s1_cia_reg;
    logic [31:0]        rf_a_q_reg;
    logic [31:0]        rf_t_q_reg;

    // writeback stage
    logic               s2_valid_reg;
    logic               s2_we_reg;
    logic               s2_load_reg;
    logic               s2_half_reg;
    logic               s2_ea0_reg;
    logic [RF_AW-1:0]   s2_idx_reg;
    logic [31:0]        s2_sum_reg;
    logic [7:0]         q_even_reg;
    logic [7:0]         q_odd_reg;

    // write of the previous edge, not yet visible in the read data
    logic               byp_valid_reg;
    logic [RF_AW-1:0]   byp_idx_reg;
    logic [31:0]        byp_data_reg;

    // architectural state
    lscbe_pkg::flags_t  flags_reg;
    lscbe_pkg::flags_t  flags_next;
    logic [63:0]        inst_cnt_reg;
    logic [63:0]        inst_cnt_next;
    logic [63:0]        cyc_cnt_reg;
    logic [63:0]        cyc_cnt_next;

    // output register
    logic               out_valid_reg;
    logic               out_taken_reg;
    logic [31:0]        out_target_reg;
    lscbe_pkg::flags_t  out_flags_reg;
    logic [63:0]        out_inst_reg;
    logic [63:0]        out_cyc_reg;

    logic               accept;
    logic               s1_adv;
    logic [31:0]        a_val;
    logic [31:0]        t_val;
    logic [31:0]        s2_wdata;
    logic [7:0]         ld_lo;
    logic [7:0]         ld_hi;
    logic [31:0]        imm32;
    logic [31:0]        sum;
    logic [MEM_AW-1:0]  ea;
    logic [MEM_AW-1:0]  ea1;
    logic [BANK_AW-1:0] row_even;
    logic [BANK_AW-1:0] row_odd;
    logic               is_load;
    logic               taken;
    logic [31:0]        target;
    logic               mem_re;
    logic               we_even;
    logic               we_odd;
    logic [BANK_AW-1:0] addr_even;
    logic [BANK_AW-1:0] addr_odd;
    logic [7:0]         wd_even;
    logic [7:0]         wd_odd;
    logic               rf_we;
    logic [RF_AW-1:0]   rf_wa;
    logic [31:0]        rf_wd;
    logic               s2_wr;

    // handshakes
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = 32'(latency_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latency_reg <= lscbe_pkg::LATENCY_RESET;
        end else if (psel && penable && pwrite && pready) begin
            latency_reg <= pwdata[LAT_W-1:0];
        end
    end

    // clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == BANK_AW'(lscbe_pkg::BANK_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // load data and writeback value
    assign ld_lo    = s2_ea0_reg ? q_odd_reg : q_even_reg;
    assign ld_hi    = s2_ea0_reg ? q_even_reg : q_odd_reg;
    assign s2_wr    = s2_valid_reg && s2_we_reg;
    always_comb begin
        if (!s2_load_reg) begin
            s2_wdata = s2_sum_reg;
        end else if (s2_half_reg) begin
            s2_wdata = {16'd0, ld_hi, ld_lo};
        end else begin
            s2_wdata = {24'd0, ld_lo};
        end
    end

    // operand forwarding
    always_comb begin
        a_val = rf_a_q_reg;
        t_val = rf_t_q_reg;
        if (byp_valid_reg && byp_idx_reg == s1_ra_reg) begin
            a_val = byp_data_reg;
        end
        if (byp_valid_reg && byp_idx_reg == s1_rt_reg) begin
            t_val = byp_data_reg;
        end
        if (s2_wr && s2_idx_reg == s1_ra_reg) begin
            a_val = s2_wdata;
        end
        if (s2_wr && s2_idx_reg == s1_rt_reg) begin
            t_val = s2_wdata;
        end
    end

    // execute
    assign imm32    = {{16{s1_imm_reg[15]}}, s1_imm_reg};
    assign sum      = a_val + imm32;
    assign ea       = a_val[MEM_AW-1:0];
    assign ea1      = ea + 1'b1;
    assign row_odd  = ea[MEM_AW-1:1];
    assign row_even = ea[0] ? ea1[MEM_AW-1:1] : ea[MEM_AW-1:1];
    assign is_load  = (s1_op_reg == lscbe_pkg::OP_LBZ) || (s1_op_reg == lscbe_pkg::OP_LHZ);

    always_comb begin
        flags_next    = flags_reg;
        inst_cnt_next = inst_cnt_reg;
        cyc_cnt_next  = cyc_cnt_reg;
        taken         = 1'b0;
        target        = '0;
        case (s1_op_reg)
            lscbe_pkg::OP_LBZ, lscbe_pkg::OP_LHZ, lscbe_pkg::OP_STB, lscbe_pkg::OP_STH: begin
                inst_cnt_next = inst_cnt_reg + 64'd1;
                cyc_cnt_next  = cyc_cnt_reg + 64'(latency_reg);
            end
            lscbe_pkg::OP_CMPI: begin
                inst_cnt_next = inst_cnt_reg + 64'd1;
                cyc_cnt_next  = cyc_cnt_reg + 64'd1;
                flags_next.lt = $signed(a_val) < $signed(imm32);
                flags_next.gt = $signed(a_val) > $signed(imm32);
                flags_next.eq = a_val == imm32;
            end
            lscbe_pkg::OP_ADDI: begin
                inst_cnt_next = inst_cnt_reg + 64'd1;
                cyc_cnt_next  = cyc_cnt_reg + 64'd1;
            end
            lscbe_pkg::OP_BEQ: begin
                if (flags_reg.eq) begin
                    taken  = 1'b1;
                    target = s1_cia_reg + imm32;
                end
            end
            lscbe_pkg::OP_B: begin
                taken  = 1'b1;
                target = s1_cia_reg + imm32;
            end
            lscbe_pkg::OP_CLR: begin
                inst_cnt_next = '0;
                cyc_cnt_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // memory bank control
    always_comb begin
        mem_re    = s1_adv && is_load;
        we_even   = 1'b0;
        we_odd    = 1'b0;
        addr_even = row_even;
        addr_odd  = row_odd;
        wd_even   = ea[0] ? t_val[15:8] : t_val[7:0];
        wd_odd    = ea[0] ? t_val[7:0] : t_val[15:8];
        if (clearing_reg) begin
            we_even   = 1'b1;
            we_odd    = 1'b1;
            addr_even = clr_cnt_reg;
            addr_odd  = clr_cnt_reg;
            wd_even   = '0;
            wd_odd    = '0;
        end else if (s1_adv) begin
            if (s1_op_reg == lscbe_pkg::OP_STH) begin
                we_even = 1'b1;
                we_odd  = 1'b1;
            end else if (s1_op_reg == lscbe_pkg::OP_STB) begin
                we_even = !ea[0];
                we_odd  = ea[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we_even) begin
            mem_even[addr_even] <= wd_even;
        end
        if (mem_re) begin
            q_even_reg <= mem_even[addr_even];
        end
    end

    always_ff @(posedge aclk) begin
        if (we_odd) begin
            mem_odd[addr_odd] <= wd_odd;
        end
        if (mem_re) begin
            q_odd_reg <= mem_odd[addr_odd];
        end
    end

    // register file
    assign rf_we = clearing_reg || s2_wr;
    assign rf_wa = clearing_reg ? RF_AW'(clr_cnt_reg) : s2_idx_reg;
    assign rf_wd = clearing_reg ? 32'd0 : s2_wdata;

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_wa] <= rf_wd;
        end
        if (accept) begin
            rf_a_q_reg <= rf_mem[RF_AW'(s_base_reg)];
            rf_t_q_reg <= rf_mem[RF_AW'(s_target_reg)];
        end else if (s1_valid_reg && !s1_adv) begin
            rf_a_q_reg <= a_val;
            rf_t_q_reg <= t_val;
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            inst_cnt_reg  <= '0;
            cyc_cnt_reg   <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            s2_valid_reg  <= s1_adv;
            byp_valid_reg <= s2_wr;
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                inst_cnt_reg  <= inst_cnt_next;
                cyc_cnt_reg   <= cyc_cnt_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg  <= s_operation;
            s1_rt_reg  <= RF_AW'(s_target_reg);
            s1_ra_reg  <= RF_AW'(s_base_reg);
            s1_imm_reg <= s_immediate;
            s1_cia_reg <= s_current_address;
        end
        if (s1_adv) begin
            s2_we_reg      <= is_load || (s1_op_reg == lscbe_pkg::OP_ADDI);
            s2_load_reg    <= is_load;
            s2_half_reg    <= s1_op_reg == lscbe_pkg::OP_LHZ;
            s2_ea0_reg     <= ea[0];
            s2_idx_reg     <= s1_rt_reg;
            s2_sum_reg     <= sum;
            out_taken_reg  <= taken;
            out_target_reg <= target;
            out_flags_reg  <= flags_next;
            out_inst_reg   <= inst_cnt_next;
            out_cyc_reg    <= cyc_cnt_next;
        end
        byp_idx_reg  <= s2_idx_reg;
        byp_data_reg <= s2_wdata;
    end

    assign m_valid             = out_valid_reg;
    assign m_branch_taken      = out_taken_reg;
    assign m_branch_target     = out_target_reg;
    assign m_flag_lt           = out_flags_reg.lt;
    assign m_flag_gt           = out_flags_reg.gt;
    assign m_flag_eq           = out_flags_reg.eq;
    assign m_instruction_count = out_inst_reg;
    assign m_cycle_count       = out_cyc_reg;

endmodule

// File: bench/tb_load_store_compare_branch_execute.sv
// Self-checking testbench for the load/store/compare/branch execute block.
module tb_load_store_compare_branch_execute;

    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam logic [lscbe_pkg::PADDR_W-1:0] LATENCY_ADDR = '0;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  rt;
        logic [2:0]  ra;
        logic [15:0] imm;
        logic [31:0] pc;
    } instr_t;

    typedef struct packed {
        logic              taken;
        logic [31:0]       target;
        lscbe_pkg::flags_t flags;
        logic [63:0]       icount;
        logic [63:0]       ccount;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_operation = '0;
    logic [2:0]  s_target_reg = '0;
    logic [2:0]  s_base_reg = '0;
    logic [15:0] s_immediate = '0;
    logic [31:0] s_current_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_branch_taken;
    logic [31:0] m_branch_target;
    logic        m_flag_lt;
    logic        m_flag_gt;
    logic        m_flag_eq;
    logic [63:0] m_instruction_count;
    logic [63:0] m_cycle_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [lscbe_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bit [7:0]          mem_image [0:lscbe_pkg::MEMORY_BYTES-1];
    bit [31:0]         reg_image [0:lscbe_pkg::REGISTER_COUNT-1];
    lscbe_pkg::flags_t flag_image = '0;
    bit [63:0]         icount_image;
    bit [63:0]         ccount_image;
    bit [9:0]          latency_image = lscbe_pkg::LATENCY_RESET;

    instr_t      instr_queue[$];
    outcome_t    outcome_queue[$];
    int          items_made;
    int          error_count;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    bit          hold_req;
    bit          idle_on = 1'b1;
    bit          word_took;

    load_store_compare_branch_execute u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_target_reg        (s_target_reg),
        .s_base_reg          (s_base_reg),
        .s_immediate         (s_immediate),
        .s_current_address   (s_current_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_branch_taken      (m_branch_taken),
        .m_branch_target     (m_branch_target),
        .m_flag_lt           (m_flag_lt),
        .m_flag_gt           (m_flag_gt),
        .m_flag_eq           (m_flag_eq),
        .m_instruction_count (m_instruction_count),
        .m_cycle_count       (m_cycle_count),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void execute_word(input instr_t w);
        logic [31:0] imm_x;
        logic [15:0] ea;
        logic [15:0] ea1;
        outcome_t    o;
        imm_x = {{16{w.imm[15]}}, w.imm};
        ea = reg_image[w.ra][15:0];
        ea1 = ea + 16'd1;
        o = '0;
        case (w.op)
            lscbe_pkg::OP_LBZ: reg_image[w.rt] = {24'd0, mem_image[ea]};
            lscbe_pkg::OP_LHZ: reg_image[w.rt] = {16'd0, mem_image[ea1], mem_image[ea]};
            lscbe_pkg::OP_STB: mem_image[ea] = reg_image[w.rt][7:0];
            lscbe_pkg::OP_STH: begin
                mem_image[ea] = reg_image[w.rt][7:0];
                mem_image[ea1] = reg_image[w.rt][15:8];
            end
            lscbe_pkg::OP_CMPI: begin
                if ($signed(reg_image[w.ra]) < $signed(imm_x))
                    flag_image = '{lt: 1'b1, gt: 1'b0, eq: 1'b0};
                else if ($signed(reg_image[w.ra]) > $signed(imm_x))
                    flag_image = '{lt: 1'b0, gt: 1'b1, eq: 1'b0};
                else
                    flag_image = '{lt: 1'b0, gt: 1'b0, eq: 1'b1};
            end
            lscbe_pkg::OP_ADDI: reg_image[w.rt] = reg_image[w.ra] + imm_x;
            lscbe_pkg::OP_BEQ: begin
                if (flag_image.eq) begin
                    o.taken = 1'b1;
                    o.target = w.pc + imm_x;
                end
            end
            lscbe_pkg::OP_B: begin
                o.taken = 1'b1;
                o.target = w.pc + imm_x;
            end
            lscbe_pkg::OP_CLR: begin
                icount_image = '0;
                ccount_image = '0;
            end
            default: ;
        endcase
        if (w.op <= lscbe_pkg::OP_ADDI) begin
            icount_image = icount_image + 64'd1;
            ccount_image = ccount_image +
                           ((w.op <= lscbe_pkg::OP_STH) ? {54'd0, latency_image} : 64'd1);
        end
        o.flags = flag_image;
        o.icount = icount_image;
        o.ccount = ccount_image;
        outcome_queue.push_back(o);
    endfunction

    function automatic void queue_word(input logic [3:0] op, input logic [2:0] rt,
                                       input logic [2:0] ra, input logic [15:0] imm,
                                       input logic [31:0] pc);
        instr_queue.push_back('{op, rt, ra, imm, pc});
        if (op <= lscbe_pkg::OP_CLR)
            items_made++;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        outcome_t want;
        instr_t   w;
        word_took = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_queue.size() == 0) begin
                $display("%0t: result word with none expected, got %b %h %b%b%b %h %h", $time,
                         m_branch_taken, m_branch_target, m_flag_lt, m_flag_gt, m_flag_eq,
                         m_instruction_count, m_cycle_count);
                error_count++;
            end else begin
                want = outcome_queue.pop_front();
                check_field("branch_taken", 64'(want.taken), 64'(m_branch_taken));
                check_field("branch_target", 64'(want.target), 64'(m_branch_target));
                check_field("flag_lt", 64'(want.flags.lt), 64'(m_flag_lt));
                check_field("flag_gt", 64'(want.flags.gt), 64'(m_flag_gt));
                check_field("flag_eq", 64'(want.flags.eq), 64'(m_flag_eq));
                check_field("instruction_count", want.icount, m_instruction_count);
                check_field("cycle_count", want.ccount, m_cycle_count);
            end
        end
        if (word_took) begin
            w = '{s_operation, s_target_reg, s_base_reg, s_immediate, s_current_address};
            execute_word(w);
        end
    end

    always @(negedge aclk) begin : word_driver
        instr_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else if (!s_valid || word_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 8);
                s_valid <= 1'b0;
            end else if (instr_queue.size() != 0) begin
                w = instr_queue.pop_front();
                s_valid <= 1'b1;
                s_operation <= w.op;
                s_target_reg <= w.rt;
                s_base_reg <= w.ra;
                s_immediate <= w.imm;
                s_current_address <= w.pc;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic wait_drained(input bit results_too);
        do
            @(posedge aclk);
        while (instr_queue.size() != 0 || s_valid ||
               (results_too && outcome_queue.size() != 0));
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= LATENCY_ADDR;
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_latency(input logic [9:0] value);
        logic [31:0] readback;
        wait_drained(1'b1);
        apb_access(1'b1, {22'd0, value}, readback);
        latency_image = value;
        apb_access(1'b0, '0, readback);
        if (readback !== {22'd0, value}) begin
            $display("%0t: memory_latency readback expected %h, got %h", $time,
                     {22'd0, value}, readback);
            error_count++;
        end
    endtask

    task automatic random_sequence(input bit synced);
        int          kind;
        int          bound;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic [2:0]  rs;
        logic [2:0]  rt;
        logic [15:0] where_to;
        logic [15:0] ea;
        kind = $urandom_range(0, 99);
        ra = $urandom_range(0, 7);
        rb = $urandom_range(0, 7);
        rs = $urandom_range(0, 7);
        rt = $urandom_range(0, 7);
        if (!synced && kind < 30)
            kind = 30 + kind % 25;
        if (kind < 15) begin
            // point a base register at a chosen address, then store and load through it
            wait_drained(1'b0);
            case ($urandom_range(0, 3))
                0: where_to = 16'hFFFF;
                1: where_to = 16'h0000;
                2: where_to = 16'hFFFE;
                default: where_to = $urandom;
            endcase
            queue_word(lscbe_pkg::OP_ADDI, rb, ra, where_to - reg_image[ra][15:0], $urandom);
            queue_word($urandom_range(0, 1) ? lscbe_pkg::OP_STH : lscbe_pkg::OP_STB,
                       rs, rb, $urandom, $urandom);
            queue_word($urandom_range(0, 1) ? lscbe_pkg::OP_LHZ : lscbe_pkg::OP_LBZ,
                       rt, rb, $urandom, $urandom);
        end else if (kind < 30) begin
            // load a known halfword and compare it against a close neighbor
            wait_drained(1'b0);
            ea = reg_image[rb][15:0];
            bound = int'({mem_image[ea + 16'd1], mem_image[ea]}) +
                    int'($urandom_range(0, 2)) - 1;
            if (bound > 32767)
                bound = 32767;
            queue_word(lscbe_pkg::OP_LHZ, rt, rb, $urandom, $urandom);
            queue_word(lscbe_pkg::OP_CMPI, $urandom, rt, bound[15:0], $urandom);
            queue_word(lscbe_pkg::OP_BEQ, $urandom, $urandom, $urandom, $urandom);
        end else if (kind < 55) begin
            queue_word($urandom_range(0, 1) ? lscbe_pkg::OP_STH : lscbe_pkg::OP_STB,
                       rs, rb, $urandom, $urandom);
            queue_word($urandom_range(0, 1) ? lscbe_pkg::OP_LHZ : lscbe_pkg::OP_LBZ,
                       rt, rb, $urandom, $urandom);
        end else if (kind < 70) begin
            queue_word(lscbe_pkg::OP_ADDI, rt, ra, $urandom, $urandom);
        end else if (kind < 85) begin
            queue_word(lscbe_pkg::OP_CMPI, rt, ra, $urandom, $urandom);
            queue_word(lscbe_pkg::OP_BEQ, $urandom, $urandom, $urandom, $urandom);
        end else if (kind < 92) begin
            queue_word(lscbe_pkg::OP_B, rt, ra, $urandom, $urandom);
        end else if (kind < 95) begin
            queue_word(lscbe_pkg::OP_CLR, rt, ra, $urandom, $urandom);
        end else begin
            queue_word($urandom_range(0, 15), rt, ra, $urandom, $urandom);
        end
    endtask

    initial begin : stimulus
        int stop_at;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_word(lscbe_pkg::OP_BEQ, 3'd0, 3'd0, 16'd4, 32'h0000_0100);
        queue_word(lscbe_pkg::OP_CMPI, 3'd7, 3'd0, 16'd0, $urandom);
        queue_word(lscbe_pkg::OP_BEQ, 3'd0, 3'd0, 16'd8, 32'hFFFF_FFFC);
        queue_word(lscbe_pkg::OP_B, 3'd0, 3'd0, 16'h8000, 32'h0000_0000);
        queue_word(lscbe_pkg::OP_B, 3'd7, 3'd7, 16'h7FFF, 32'hFFFF_FFFF);
        queue_word(lscbe_pkg::OP_ADDI, 3'd1, 3'd0, 16'hFFFF, $urandom);
        queue_word(lscbe_pkg::OP_ADDI, 3'd2, 3'd0, 16'h7ABC, $urandom);
        queue_word(lscbe_pkg::OP_STH, 3'd2, 3'd1, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_LHZ, 3'd3, 3'd1, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_LBZ, 3'd4, 3'd0, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_LBZ, 3'd5, 3'd1, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_STB, 3'd1, 3'd2, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_LHZ, 3'd7, 3'd2, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_CMPI, 3'd0, 3'd1, 16'd0, $urandom);
        queue_word(lscbe_pkg::OP_CMPI, 3'd0, 3'd2, 16'h8000, $urandom);
        queue_word(lscbe_pkg::OP_CMPI, 3'd0, 3'd1, 16'hFFFF, $urandom);
        queue_word(lscbe_pkg::OP_BEQ, 3'd0, 3'd0, 16'hFFFE, 32'h8000_0000);
        queue_word(lscbe_pkg::OP_CMPI, 3'd0, 3'd2, 16'h7FFF, $urandom);
        queue_word(lscbe_pkg::OP_BEQ, 3'd0, 3'd0, 16'h0010, $urandom);
        queue_word(lscbe_pkg::OP_CLR, $urandom, $urandom, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_ADDI, 3'd7, 3'd7, 16'h7FFF, $urandom);
        queue_word(OP_UNUSED_LO, $urandom, $urandom, $urandom, $urandom);
        queue_word(OP_UNUSED_HI, $urandom, $urandom, $urandom, $urandom);
        queue_word(lscbe_pkg::OP_LHZ, 3'd0, 3'd0, $urandom, $urandom);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: set_latency(10'd1);
                2: set_latency(10'd1023);
                3: set_latency(10'd0);
                4: set_latency($urandom_range(2, 1022));
                default: ;
            endcase
            idle_on = (phase != 4);
            if (phase == 1) begin
                // stall the result side while words keep coming
                hold_req = 1'b1;
                repeat (12) random_sequence(1'b0);
            end
            stop_at = items_made + 255;
            while (items_made < stop_at)
                random_sequence(phase != 4);
        end

        wait_drained(1'b1);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("[load_store_compare_branch_execute] OK");
        else
            $display("[load_store_compare_branch_execute] ERROR");
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("[load_store_compare_branch_execute] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lscbe_pkg.sv
rtl/load_store_compare_branch_execute.sv
bench/tb_load_store_compare_branch_execute.sv
